// ----- sv/siphash_1_3_string_hash_macros.svh -----
// assertion helpers shared by the siphash block
`ifndef SIPHASH_1_3_STRING_HASH_MACROS_SVH
`define SIPHASH_1_3_STRING_HASH_MACROS_SVH

// checked only while out of reset
`define SH13_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SH13_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/sh13_pkg.sv -----
package sh13_pkg;

    localparam logic [63:0] INIT_C0 = 64'h736F6D6570736575;
    localparam logic [63:0] INIT_C1 = 64'h646F72616E646F6D;
    localparam logic [63:0] INIT_C2 = 64'h6C7967656E657261;
    localparam logic [63:0] INIT_C3 = 64'h7465646279746573;
    localparam logic [63:0] FINAL_XOR = 64'h00000000000000FF;

    localparam logic [63:0] KEY_LOW_RESET  = 64'h0706050403020100;
    localparam logic [63:0] KEY_HIGH_RESET = 64'h0F0E0D0C0B0A0908;

    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LOW  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_HIGH = 8'd1;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } t_lanes;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int s);
        return (x << s) | (x >> (64 - s));
    endfunction

    function automatic t_lanes sip_round(input t_lanes l);
        t_lanes r;
        r = l;
        r.v0 = r.v0 + r.v1;
        r.v1 = rotl64(r.v1, 13) ^ r.v0;
        r.v0 = rotl64(r.v0, 32);
        r.v2 = r.v2 + r.v3;
        r.v3 = rotl64(r.v3, 16) ^ r.v2;
        r.v0 = r.v0 + r.v3;
        r.v3 = rotl64(r.v3, 21) ^ r.v0;
        r.v2 = r.v2 + r.v1;
        r.v1 = rotl64(r.v1, 17) ^ r.v2;
        r.v2 = rotl64(r.v2, 32);
        return r;
    endfunction

    function automatic t_lanes sip_absorb(input t_lanes l, input logic [63:0] m);
        t_lanes r;
        r = l;
        r.v3 = r.v3 ^ m;
        r = sip_round(r);
        r.v0 = r.v0 ^ m;
        return r;
    endfunction

    function automatic t_lanes sip_rearm(input logic [63:0] k_lo, input logic [63:0] k_hi);
        t_lanes r;
        r.v0 = k_lo ^ INIT_C0;
        r.v1 = k_hi ^ INIT_C1;
        r.v2 = k_lo ^ INIT_C2;
        r.v3 = k_hi ^ INIT_C3;
        return r;
    endfunction

    function automatic logic [63:0] sip_fold(input t_lanes l);
        return l.v0 ^ l.v1 ^ l.v2 ^ l.v3;
    endfunction

endpackage

// ----- sv/siphash_1_3_string_hash.sv -----
// SipHash-1-3 over a byte stream, one byte per transfer, keyed by two 64-bit
// registers (index 0 low half, index 1 high half; a key write re-arms the lanes
// and drops any message in progress). The block takes one input transfer every
// cycle unless the finalization pipeline is full and stalled: the state stage
// packs bytes and runs the compression round for a full block in the cycle its
// eighth byte arrives. An item with end_of_message set hands the lanes and the
// final block to a four-stage finalization pipeline (final absorb, then one
// SipRound per stage) followed by the output register that offers the hash,
// and a new message may start in the very next cycle. Up to five finished
// or in-flight hashes are held if the output stalls before input ready drops.
`include "siphash_1_3_string_hash_macros.svh"

module siphash_1_3_string_hash
    import sh13_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [63:0]            i_cfg_data,
    // byte input channel
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_byte_present,
    input  logic                   i_end_of_message,
    // hash output channel
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [63:0]            o_hash_value
);

    // key and message state
    logic [63:0] r_key_lo;
    logic [63:0] r_key_hi;
    t_lanes      r_lanes;
    logic [55:0] r_part;
    logic [2:0]  r_cnt;
    logic [7:0]  r_len;

    // finalization pipeline
    logic [3:0]  r_pv;
    t_lanes      r_pl [0:3];
    logic [63:0] r_m;
    logic        r_o_valid;
    logic [63:0] r_hash;

    logic        in_xfer;
    logic        cfg_xfer;
    logic [3:0]  go;
    logic        out_free;

    t_lanes      absorbed;
    t_lanes      mid;
    logic [55:0] part_upd;
    logic [2:0]  cnt_upd;
    logic [7:0]  len_upd;
    logic [63:0] fin_m;
    t_lanes      st1_in;
    t_lanes      st2_in;
    t_lanes      st3_in;
    logic [63:0] hash_in;

    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid;

    // a stage can load when empty or when its content moves on
    assign out_free = !r_o_valid || i_ready;
    assign go[3]    = !r_pv[3] || out_free;
    assign go[2]    = !r_pv[2] || go[3];
    assign go[1]    = !r_pv[1] || go[2];
    assign go[0]    = !r_pv[0] || go[1];

    assign o_ready = go[0];
    assign in_xfer = i_valid && o_ready;

    // byte packing and full-block absorb
    always_comb begin
        absorbed = sip_absorb(r_lanes, {i_data_byte, r_part});
        mid      = r_lanes;
        part_upd = r_part;
        cnt_upd  = r_cnt;
        len_upd  = r_len;
        if (i_byte_present) begin
            len_upd = r_len + 8'd1;
            if (r_cnt == 3'd7) begin
                mid      = absorbed;
                part_upd = '0;
                cnt_upd  = '0;
            end else begin
                for (int i = 0; i < 7; i++) begin
                    if (r_cnt == 3'(i)) begin
                        part_upd[8*i +: 8] = i_data_byte;
                    end
                end
                cnt_upd = r_cnt + 3'd1;
            end
        end
        fin_m = {len_upd, part_upd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo <= KEY_LOW_RESET;
            r_key_hi <= KEY_HIGH_RESET;
            r_lanes  <= sip_rearm(KEY_LOW_RESET, KEY_HIGH_RESET);
            r_part   <= '0;
            r_cnt    <= '0;
            r_len    <= '0;
        end else if (cfg_xfer) begin
            case (i_cfg_index)
                CFG_KEY_LOW: begin
                    r_key_lo <= i_cfg_data;
                    r_lanes  <= sip_rearm(i_cfg_data, r_key_hi);
                    r_part   <= '0;
                    r_cnt    <= '0;
                    r_len    <= '0;
                end
                CFG_KEY_HIGH: begin
                    r_key_hi <= i_cfg_data;
                    r_lanes  <= sip_rearm(r_key_lo, i_cfg_data);
                    r_part   <= '0;
                    r_cnt    <= '0;
                    r_len    <= '0;
                end
                default: begin
                end
            endcase
        end else if (in_xfer) begin
            if (i_end_of_message) begin
                r_lanes <= sip_rearm(r_key_lo, r_key_hi);
                r_part  <= '0;
                r_cnt   <= '0;
                r_len   <= '0;
            end else begin
                r_lanes <= mid;
                r_part  <= part_upd;
                r_cnt   <= cnt_upd;
                r_len   <= len_upd;
            end
        end
    end

    // one round per stage
    always_comb begin
        st1_in    = sip_absorb(r_pl[0], r_m);
        st1_in.v2 = st1_in.v2 ^ FINAL_XOR;
        st2_in    = sip_round(r_pl[1]);
        st3_in    = sip_round(r_pl[2]);
        hash_in   = sip_fold(sip_round(r_pl[3]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (go[0]) r_pv[0] <= in_xfer && i_end_of_message;
            if (go[1]) r_pv[1] <= r_pv[0];
            if (go[2]) r_pv[2] <= r_pv[1];
            if (go[3]) r_pv[3] <= r_pv[2];
            if (out_free) r_o_valid <= r_pv[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (go[0]) begin
            r_pl[0] <= mid;
            r_m     <= fin_m;
        end
        if (go[1]) r_pl[1] <= st1_in;
        if (go[2]) r_pl[2] <= st2_in;
        if (go[3]) r_pl[3] <= st3_in;
        if (out_free) r_hash <= hash_in;
    end

    assign o_valid      = r_o_valid;
    assign o_hash_value = r_hash;

    `SH13_ASSERT(a_close_clears_state, (in_xfer && i_end_of_message && !cfg_xfer) |=> (r_cnt == 3'd0 && r_len == 8'd0), "closing transfer left message state behind")
    `SH13_ASSERT(a_close_enters_pipe, (in_xfer && i_end_of_message) |=> r_pv[0], "closing transfer did not reach the finalization pipeline")
    `SH13_ASSERT(a_full_pipe_stalls, (r_o_valid && !i_ready && (&r_pv)) |-> !o_ready, "input taken while finalization pipeline is full and stalled")
    `SH13_ASSERT(a_cfg_drops_message, (cfg_xfer && (i_cfg_index == CFG_KEY_LOW || i_cfg_index == CFG_KEY_HIGH)) |=> (r_cnt == 3'd0 && r_len == 8'd0), "key write did not re-arm")
    `SH13_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> (!r_o_valid && r_pv == 4'd0), "reset left a hash pending")

endmodule
